// ===== src/dro_pkg.sv =====
`timescale 1ns / 1ps

package dro_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned DATE_W  = YEAR_W + MONTH_W + DAY_W;
    localparam int unsigned NUM_DATES = 4;
    localparam int unsigned IN_W    = DATE_W * NUM_DATES;
    localparam int unsigned IN_TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int unsigned YY_W    = 15;
    localparam int unsigned Q_W     = 8;
    localparam int unsigned DN_W    = 23;
    localparam int unsigned CNT_W   = 22;
    localparam int unsigned OUT_TDATA_W = ((CNT_W + 7) / 8) * 8;
    localparam int unsigned PROD_W  = 30;

    localparam logic [YY_W-1:0]   YEAR_SHIFT  = 15'd399;
    localparam logic [PROD_W-1:0] RECIP_100   = 30'd20972;
    localparam int unsigned       RECIP_SHIFT = 21;
    localparam logic [DN_W-1:0]   DAYS_YEAR   = 23'd365;
    localparam logic [CNT_W:0]    COUNT_MAX   = 23'd4194303;

    localparam int unsigned OP_W    = 3;
    localparam int unsigned STEP_W  = 3;

    localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
    localparam logic [OP_W-1:0] OP_MULQ  = 3'd1;
    localparam logic [OP_W-1:0] OP_M365  = 3'd2;
    localparam logic [OP_W-1:0] OP_ADDC  = 3'd3;
    localparam logic [OP_W-1:0] OP_ADDM  = 3'd4;
    localparam logic [OP_W-1:0] OP_RANGE = 3'd5;
    localparam logic [OP_W-1:0] OP_COUNT = 3'd6;
    localparam logic [OP_W-1:0] OP_DONE  = 3'd7;

    localparam logic JMP_NONE     = 1'b0;
    localparam logic JMP_NOT_LAST = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic            run;
        logic            load;
        logic [OP_W-1:0] op;
    } t_ctrl;

    typedef struct packed {
        logic last_date;
    } t_stat;

    typedef struct packed {
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        logic [YEAR_W-1:0]  y;
    } t_date;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        logic [DAY_W-1:0] len;
        len = '0;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] n;
        n = '0;
        unique case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== src/dro_urom.sv =====
`timescale 1ns / 1ps

module dro_urom
    import dro_pkg::*;
(
    input  logic [STEP_W-1:0] i_step,
    output t_uword            o_word
);

    always_comb begin
        unique case (i_step)
            3'd0: o_word = '{op: OP_LOAD,  cond: JMP_NONE,     target: 3'd0};
            3'd1: o_word = '{op: OP_MULQ,  cond: JMP_NONE,     target: 3'd0};
            3'd2: o_word = '{op: OP_M365,  cond: JMP_NONE,     target: 3'd0};
            3'd3: o_word = '{op: OP_ADDC,  cond: JMP_NONE,     target: 3'd0};
            3'd4: o_word = '{op: OP_ADDM,  cond: JMP_NOT_LAST, target: 3'd0};
            3'd5: o_word = '{op: OP_RANGE, cond: JMP_NONE,     target: 3'd0};
            3'd6: o_word = '{op: OP_COUNT, cond: JMP_NONE,     target: 3'd0};
            3'd7: o_word = '{op: OP_DONE,  cond: JMP_NONE,     target: 3'd0};
        endcase
    end

endmodule

// ===== src/dro_seq.sv =====
`timescale 1ns / 1ps

module dro_seq
    import dro_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output logic  o_done
);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic              n_busy;
    logic [STEP_W-1:0] n_step;
    t_uword            w_word;
    logic              w_accept;
    logic              w_jump;

    dro_urom u_urom (
        .i_step (r_step),
        .o_word (w_word)
    );

    assign o_in_ready = !r_busy;
    assign w_accept   = i_in_valid && !r_busy;
    assign w_jump     = (w_word.cond == JMP_NOT_LAST) && !i_stat.last_date;
    assign o_done     = r_busy && (w_word.op == OP_DONE) && i_out_free;

    assign o_ctrl.run  = r_busy;
    assign o_ctrl.load = w_accept;
    assign o_ctrl.op   = w_word.op;

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (w_accept) begin
            n_busy = 1'b1;
            n_step = '0;
        end else if (r_busy) begin
            if (w_word.op == OP_DONE) begin
                if (i_out_free) begin
                    n_busy = 1'b0;
                end
            end else if (w_jump) begin
                n_step = w_word.target;
            end else begin
                n_step = r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

endmodule

// ===== src/dro_datapath.sv =====
`timescale 1ns / 1ps

module dro_datapath
    import dro_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl                 i_ctrl,
    input  logic [IN_W-1:0]       i_dates,
    output t_stat                 o_stat,
    output logic [CNT_W-1:0]      o_cnt,
    output logic                  o_bad
);

    t_date             r_date [NUM_DATES];
    logic [1:0]        r_idx;
    logic [YEAR_W-1:0] r_y;
    logic [MONTH_W-1:0] r_m;
    logic [DAY_W-1:0]  r_d;
    logic [YY_W-1:0]   r_yy;
    logic [Q_W-1:0]    r_q100;
    logic [Q_W-1:0]    r_qy;
    logic [DN_W-1:0]   r_acc;
    logic              r_leap;
    logic [DN_W-1:0]   r_dn [NUM_DATES];
    logic              r_bad;
    logic [DN_W-1:0]   r_lo;
    logic [DN_W-1:0]   r_hi;
    logic              r_ok;
    logic [CNT_W-1:0]  r_cnt;

    t_date             w_sel;
    logic [PROD_W-1:0] w_pyy;
    logic [PROD_W-1:0] w_py;
    logic [YEAR_W-1:0] w_rem;
    logic [DAY_W-1:0]  w_lim;
    logic              w_date_ok;
    logic              w_adj;
    logic [DN_W-1:0]   w_lo;
    logic [DN_W-1:0]   w_hi;
    logic [CNT_W:0]    w_span;

    assign w_sel = r_date[r_idx];
    assign w_pyy = PROD_W'(r_yy) * RECIP_100;
    assign w_py  = PROD_W'(r_y) * RECIP_100;
    assign w_rem = r_y - (YEAR_W'(r_qy) * YEAR_W'(100));
    assign w_lim = month_len(r_m, r_leap);
    assign w_date_ok = (r_m >= 4'd1) && (r_m <= 4'd12) && (r_d >= 5'd1) && (r_d <= w_lim);
    assign w_adj = (r_m > 4'd2) && r_leap;
    assign w_lo  = (r_dn[0] > r_dn[2]) ? r_dn[0] : r_dn[2];
    assign w_hi  = (r_dn[1] < r_dn[3]) ? r_dn[1] : r_dn[3];
    assign w_span = (CNT_W+1)'(r_hi - r_lo) + 1'b1;

    assign o_stat.last_date = (r_idx == 2'd3);
    assign o_cnt = r_cnt;
    assign o_bad = r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_bad <= 1'b0;
        end else if (i_ctrl.load) begin
            r_idx <= '0;
            r_bad <= 1'b0;
        end else if (i_ctrl.run && i_ctrl.op == OP_ADDM) begin
            r_idx <= r_idx + 1'b1;
            r_bad <= r_bad | !w_date_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            for (int i = 0; i < NUM_DATES; i++) begin
                r_date[i] <= i_dates[i*DATE_W +: DATE_W];
            end
        end else if (i_ctrl.run) begin
            unique case (i_ctrl.op)
                OP_LOAD: begin
                    r_y  <= w_sel.y;
                    r_m  <= w_sel.m;
                    r_d  <= w_sel.d;
                    r_yy <= YY_W'(w_sel.y) + YEAR_SHIFT;
                end
                OP_MULQ: begin
                    r_q100 <= w_pyy[RECIP_SHIFT +: Q_W];
                    r_qy   <= w_py[RECIP_SHIFT +: Q_W];
                end
                OP_M365: begin
                    r_acc  <= DN_W'(r_yy) * DAYS_YEAR;
                    r_leap <= (r_y[1:0] == 2'd0) && ((w_rem != '0) || (r_qy[1:0] == 2'd0));
                end
                OP_ADDC: begin
                    r_acc <= r_acc + DN_W'(r_yy >> 2) - DN_W'(r_q100) + DN_W'(r_q100 >> 2);
                end
                OP_ADDM: begin
                    r_dn[r_idx] <= r_acc + DN_W'(days_before(r_m)) + DN_W'(w_adj)
                                   + DN_W'(r_d);
                end
                OP_RANGE: begin
                    r_lo <= w_lo;
                    r_hi <= w_hi;
                    r_ok <= (r_dn[0] <= r_dn[1]) && (r_dn[2] <= r_dn[3]) && (w_lo <= w_hi);
                end
                OP_COUNT: begin
                    if (r_bad || !r_ok) begin
                        r_cnt <= '0;
                    end else if (w_span > COUNT_MAX) begin
                        r_cnt <= COUNT_MAX[CNT_W-1:0];
                    end else begin
                        r_cnt <= w_span[CNT_W-1:0];
                    end
                end
                OP_DONE: begin
                end
            endcase
        end
    end

endmodule

// ===== src/date_range_overlap_days.sv =====
`timescale 1ns / 1ps
// Each item runs through the microprogram: five steps per date for four dates,
// then range, count and done steps; s_axis_tready is low meanwhile, so a new item
// is taken only after the done step of the last one.
// A finished result waits in the output register; the done step holds until it is free.
// Reset (synchronous, active low) clears the sequencer and the output valid flag.

module date_range_overlap_days
    import dro_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // first_start_year, first_start_month, first_start_day, first_end_year,
    // first_end_month, first_end_day, second_start_year, second_start_month,
    // second_start_day, second_end_year, second_end_month, second_end_day, pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // overlap_days, pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // invalid_date
    output logic                   m_axis_tuser
);

    t_ctrl            w_ctrl;
    t_stat            w_stat;
    logic             w_done;
    logic             w_out_free;
    logic [CNT_W-1:0] w_cnt;
    logic             w_bad;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_out_cnt;
    logic             r_out_bad;

    assign w_out_free = !r_out_valid || m_axis_tready;

    dro_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl),
        .o_done     (w_done)
    );

    dro_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_dates (s_axis_tdata[IN_W-1:0]),
        .o_stat  (w_stat),
        .o_cnt   (w_cnt),
        .o_bad   (w_bad)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_cnt <= w_cnt;
            r_out_bad <= w_bad;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_cnt);
    assign m_axis_tuser  = r_out_bad;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_bad |-> r_out_cnt == '0)
        else $error("invalid result carries a nonzero count");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("new transfer taken while an item is in work");

    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> !(r_out_valid && !m_axis_tready))
        else $error("result written over a waiting result");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> (CNT_W+1)'(r_out_cnt) <= COUNT_MAX)
        else $error("count above saturation limit");

endmodule
